// ===== rtl/u8dv_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dv_pkg: shared types and constants for the UTF-8 stream decoder
// Byte classes produced by the front end, continuation limits kept by the
// back end, and the queue entry that carries a classified byte between them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8dv_pkg;

  // Width of the per-string character counter (saturating).
  localparam int COUNT_WIDTH = 16;
  // Width of the reported character total.
  localparam int TOTAL_WIDTH = 16;
  // Width of a decoded code point.
  localparam int CP_WIDTH    = 21;

  // Queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Class of one raw byte, independent of decoder state.
  typedef enum logic [3:0] {
    BC_ASCII,     // 0x00..0x7F
    BC_LEAD2,     // 0xC2..0xDF
    BC_LEAD3,     // 0xE1..0xEC, 0xEE..0xEF
    BC_LEAD3_E0,  // 0xE0
    BC_LEAD3_ED,  // 0xED
    BC_LEAD4,     // 0xF1..0xF3
    BC_LEAD4_F0,  // 0xF0
    BC_LEAD4_F4,  // 0xF4
    BC_CONT_8X,   // 0x80..0x8F
    BC_CONT_9X,   // 0x90..0x9F
    BC_CONT_AB,   // 0xA0..0xBF
    BC_BAD        // 0xC0, 0xC1, 0xF5..0xFF
  } byte_class_t;

  // Limit on the next continuation byte, set by the lead byte.
  typedef enum logic [2:0] {
    LIM_ANY,  // 0x80..0xBF
    LIM_E0,   // 0xA0..0xBF
    LIM_ED,   // 0x80..0x9F
    LIM_F0,   // 0x90..0xBF
    LIM_F4    // 0x80..0x8F
  } cont_limit_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
    logic        eos;
  } item_t;

endpackage : u8dv_pkg

`default_nettype wire

// ===== rtl/u8dv_front.sv =====
// ----------------------------------------------------------------------------
// u8dv_front: input stage and byte classifier
// Accepts one byte request per cycle while the queue keeps taking them,
// classifies it and holds it in a register until the queue takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8dv_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_end_of_string,
  output      logic            push_valid,
  input  wire logic            push_ready,
  output      u8dv_pkg::item_t push_item
);

  logic                  stage_valid_r;
  logic                  stage_valid_nxt;
  u8dv_pkg::item_t       stage_item_r;
  u8dv_pkg::byte_class_t cls;
  logic                  accept;
  logic                  push;

  // Classify the incoming byte by range.
  always_comb begin
    case (in_data_byte) inside
      [8'h00:8'h7F]:               cls = u8dv_pkg::BC_ASCII;
      [8'h80:8'h8F]:               cls = u8dv_pkg::BC_CONT_8X;
      [8'h90:8'h9F]:               cls = u8dv_pkg::BC_CONT_9X;
      [8'hA0:8'hBF]:               cls = u8dv_pkg::BC_CONT_AB;
      [8'hC2:8'hDF]:               cls = u8dv_pkg::BC_LEAD2;
      8'hE0:                       cls = u8dv_pkg::BC_LEAD3_E0;
      8'hED:                       cls = u8dv_pkg::BC_LEAD3_ED;
      [8'hE1:8'hEC], [8'hEE:8'hEF]: cls = u8dv_pkg::BC_LEAD3;
      8'hF0:                       cls = u8dv_pkg::BC_LEAD4_F0;
      [8'hF1:8'hF3]:               cls = u8dv_pkg::BC_LEAD4;
      8'hF4:                       cls = u8dv_pkg::BC_LEAD4_F4;
      default:                     cls = u8dv_pkg::BC_BAD;
    endcase
  end

  // Handshakes on both sides of the stage register.
  assign push       = stage_valid_r && push_ready;
  assign in_ready   = !stage_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = stage_valid_r;
  assign push_item  = stage_item_r;

  always_comb begin
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (push) begin
      stage_valid_nxt = 1'b0;
    end else begin
      stage_valid_nxt = stage_valid_r;
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item_r.cls  <= cls;
      stage_item_r.data <= in_data_byte;
      stage_item_r.eos  <= in_end_of_string;
    end
  end

endmodule : u8dv_front

`default_nettype wire

// ===== rtl/u8dv_queue.sv =====
// ----------------------------------------------------------------------------
// u8dv_queue: small FIFO between front and back end
// Holds classified byte requests so that each side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8dv_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output      logic            push_ready,
  input  wire u8dv_pkg::item_t push_item,
  output      logic            pop_valid,
  input  wire logic            pop_ready,
  output      u8dv_pkg::item_t pop_item
);

  u8dv_pkg::item_t                   entries_r [u8dv_pkg::QUEUE_DEPTH];
  logic [u8dv_pkg::QUEUE_AW-1:0]     wr_ptr_r;
  logic [u8dv_pkg::QUEUE_AW-1:0]     wr_ptr_nxt;
  logic [u8dv_pkg::QUEUE_AW-1:0]     rd_ptr_r;
  logic [u8dv_pkg::QUEUE_AW-1:0]     rd_ptr_nxt;
  logic [u8dv_pkg::QUEUE_CW-1:0]     count_r;
  logic [u8dv_pkg::QUEUE_CW-1:0]     count_nxt;
  logic                              push;
  logic                              pop;

  assign push_ready = (count_r != u8dv_pkg::QUEUE_CW'(u8dv_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : u8dv_queue

`default_nettype wire

// ===== rtl/u8dv_back.sv =====
// ----------------------------------------------------------------------------
// u8dv_back: sequence decoder and result register
// Runs the strict UTF-8 state machine on classified bytes, counts characters
// and registers one result per byte that completes, breaks or ends a string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8dv_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              pop_valid,
  output      logic                              pop_ready,
  input  wire u8dv_pkg::item_t                   pop_item,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [u8dv_pkg::CP_WIDTH-1:0]     out_code_point,
  output      logic                              out_char_done,
  output      logic                              out_seq_error,
  output      logic                              out_string_done,
  output      logic                              out_string_valid,
  output      logic [u8dv_pkg::TOTAL_WIDTH-1:0]  out_char_total
);

  // Decoder state.
  logic [1:0]                         pending_r, pending_nxt;
  logic [u8dv_pkg::CP_WIDTH-1:0]      partial_r, partial_nxt;
  u8dv_pkg::cont_limit_t              limit_r, limit_nxt;
  logic                               err_latched_r, err_latched_nxt;
  logic [u8dv_pkg::COUNT_WIDTH-1:0]   tally_r, tally_nxt;

  // Result register.
  logic                               out_valid_r, out_valid_nxt;
  logic [u8dv_pkg::CP_WIDTH-1:0]      cp_r;
  logic                               done_r, err_r, eos_r, str_valid_r;
  logic [u8dv_pkg::TOTAL_WIDTH-1:0]   total_r;

  // Per-byte working values.
  logic                               pop;
  logic                               done;
  logic                               err;
  logic                               cont_ok;
  logic [u8dv_pkg::CP_WIDTH-1:0]      cp;
  logic [u8dv_pkg::CP_WIDTH-1:0]      shifted;
  logic [1:0]                         pend_work;
  logic [63:0]                        tally_wide;
  logic [u8dv_pkg::TOTAL_WIDTH-1:0]   total;
  logic                               has_result;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign shifted   = {partial_r[u8dv_pkg::CP_WIDTH-7:0], pop_item.data[5:0]};

  // Check the byte against the continuation limit left by the lead byte.
  always_comb begin
    case (limit_r)
      u8dv_pkg::LIM_E0: cont_ok = (pop_item.cls == u8dv_pkg::BC_CONT_AB);
      u8dv_pkg::LIM_ED: cont_ok = (pop_item.cls == u8dv_pkg::BC_CONT_8X) ||
                                  (pop_item.cls == u8dv_pkg::BC_CONT_9X);
      u8dv_pkg::LIM_F0: cont_ok = (pop_item.cls == u8dv_pkg::BC_CONT_9X) ||
                                  (pop_item.cls == u8dv_pkg::BC_CONT_AB);
      u8dv_pkg::LIM_F4: cont_ok = (pop_item.cls == u8dv_pkg::BC_CONT_8X);
      default:          cont_ok = (pop_item.cls == u8dv_pkg::BC_CONT_8X) ||
                                  (pop_item.cls == u8dv_pkg::BC_CONT_9X) ||
                                  (pop_item.cls == u8dv_pkg::BC_CONT_AB);
    endcase
  end

  // Decode step for the byte at the head of the queue.
  always_comb begin
    pending_nxt     = pending_r;
    partial_nxt     = partial_r;
    limit_nxt       = limit_r;
    err_latched_nxt = err_latched_r;
    tally_nxt       = tally_r;
    done            = 1'b0;
    err             = 1'b0;
    cp              = '0;
    pend_work       = pending_r;

    if (!err_latched_r) begin
      if (pending_r == 2'd0) begin
        case (pop_item.cls)
          u8dv_pkg::BC_ASCII: begin
            cp   = u8dv_pkg::CP_WIDTH'(pop_item.data);
            done = 1'b1;
          end
          u8dv_pkg::BC_LEAD2: begin
            partial_nxt = u8dv_pkg::CP_WIDTH'(pop_item.data[4:0]);
            pend_work   = 2'd1;
            limit_nxt   = u8dv_pkg::LIM_ANY;
          end
          u8dv_pkg::BC_LEAD3, u8dv_pkg::BC_LEAD3_E0, u8dv_pkg::BC_LEAD3_ED: begin
            partial_nxt = u8dv_pkg::CP_WIDTH'(pop_item.data[3:0]);
            pend_work   = 2'd2;
            if (pop_item.cls == u8dv_pkg::BC_LEAD3_E0) begin
              limit_nxt = u8dv_pkg::LIM_E0;
            end else if (pop_item.cls == u8dv_pkg::BC_LEAD3_ED) begin
              limit_nxt = u8dv_pkg::LIM_ED;
            end else begin
              limit_nxt = u8dv_pkg::LIM_ANY;
            end
          end
          u8dv_pkg::BC_LEAD4, u8dv_pkg::BC_LEAD4_F0, u8dv_pkg::BC_LEAD4_F4: begin
            partial_nxt = u8dv_pkg::CP_WIDTH'(pop_item.data[2:0]);
            pend_work   = 2'd3;
            if (pop_item.cls == u8dv_pkg::BC_LEAD4_F0) begin
              limit_nxt = u8dv_pkg::LIM_F0;
            end else if (pop_item.cls == u8dv_pkg::BC_LEAD4_F4) begin
              limit_nxt = u8dv_pkg::LIM_F4;
            end else begin
              limit_nxt = u8dv_pkg::LIM_ANY;
            end
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end else if (cont_ok) begin
        partial_nxt = shifted;
        limit_nxt   = u8dv_pkg::LIM_ANY;
        pend_work   = pending_r - 2'd1;
        if (pend_work == 2'd0) begin
          cp   = shifted;
          done = 1'b1;
        end
      end else begin
        err = 1'b1;
      end

      // A final byte that leaves a sequence open truncates the string.
      if (pop_item.eos && !err && (pend_work != 2'd0)) begin
        err = 1'b1;
      end

      pending_nxt = pend_work;
      if (err) begin
        err_latched_nxt = 1'b1;
        pending_nxt     = 2'd0;
        partial_nxt     = '0;
        limit_nxt       = u8dv_pkg::LIM_ANY;
      end

      if (done && (tally_r != '1)) begin
        tally_nxt = tally_r + 1'b1;
      end
    end
  end

  // Saturate the counter to the reported width.
  always_comb begin
    tally_wide = 64'(tally_nxt);
    if (tally_wide > 64'(16'hFFFF)) begin
      total = '1;
    end else begin
      total = tally_wide[u8dv_pkg::TOTAL_WIDTH-1:0];
    end
  end

  assign has_result = done || err || pop_item.eos;

  always_comb begin
    if (pop) begin
      out_valid_nxt = has_result;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  // Control state; the end of a string returns the decoder to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r     <= 2'd0;
      partial_r     <= '0;
      limit_r       <= u8dv_pkg::LIM_ANY;
      err_latched_r <= 1'b0;
      tally_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (pop_item.eos) begin
          pending_r     <= 2'd0;
          partial_r     <= '0;
          limit_r       <= u8dv_pkg::LIM_ANY;
          err_latched_r <= 1'b0;
          tally_r       <= '0;
        end else begin
          pending_r     <= pending_nxt;
          partial_r     <= partial_nxt;
          limit_r       <= limit_nxt;
          err_latched_r <= err_latched_nxt;
          tally_r       <= tally_nxt;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      cp_r        <= cp;
      done_r      <= done;
      err_r       <= err;
      eos_r       <= pop_item.eos;
      str_valid_r <= pop_item.eos && !err_latched_nxt;
      total_r     <= pop_item.eos ? total : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = cp_r;
  assign out_char_done    = done_r;
  assign out_seq_error    = err_r;
  assign out_string_done  = eos_r;
  assign out_string_valid = str_valid_r;
  assign out_char_total   = total_r;

endmodule : u8dv_back

`default_nettype wire

// ===== rtl/utf8_stream_decode_validate.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decode_validate: strict UTF-8 stream decoder and validator
// Decodes a byte stream into code points and reports per-string validity.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request carries one byte and an end-of-string flag. A result
//   request is sent for every byte that completes a character, for the
//   first byte that breaks the string, and for the final byte of a string,
//   which also carries the validity flag and the saturating character total.
//   Lead and inner continuation bytes, and bytes after an error, give none.
//   Throughput is one byte per cycle while the receiver keeps taking results:
//   the decode step for one byte is shallow logic in the back end.
//   An accepted byte loads the classifier register, is then written into
//   the four-entry queue, and its decode step then loads the result register
//   and raises out_valid when the byte gives a result.
//   When the receiver stalls the result register holds, the queue fills,
//   and in_ready falls once the queue and classifier register are full.
//   Synchronous reset empties the queue, drops out_valid and clears the
//   decoder state and character count; the end of every string does the
//   same for the decoder state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decode_validate (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [7:0]                        in_data_byte,
  input  wire logic                              in_end_of_string,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [u8dv_pkg::CP_WIDTH-1:0]     out_code_point,
  output      logic                              out_char_done,
  output      logic                              out_seq_error,
  output      logic                              out_string_done,
  output      logic                              out_string_valid,
  output      logic [u8dv_pkg::TOTAL_WIDTH-1:0]  out_char_total
);

  logic            push_valid;
  logic            push_ready;
  u8dv_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  u8dv_pkg::item_t pop_item;

  // Input stage and classifier.
  u8dv_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_item        (push_item)
  );

  // Queue between the two halves.
  u8dv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Decoder and result register.
  u8dv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_char_done    (out_char_done),
    .out_seq_error    (out_seq_error),
    .out_string_done  (out_string_done),
    .out_string_valid (out_string_valid),
    .out_char_total   (out_char_total)
  );

endmodule : utf8_stream_decode_validate

`default_nettype wire

// ===== bench/tb_utf8_stream_decode_validate.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_stream_decode_validate: self-checking bench for the UTF-8 decoder
// Feeds byte strings through the valid/ready input channel and predicts every
// result request with a local decoder. Results are compared field by field in
// arrival order. Directed strings hit the encoding boundaries and each kind of
// malformed input, and random strings mix well-formed text, broken sequences
// and noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_stream_decode_validate;

  // One byte request as it waits in the stimulus queue.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } byte_req_t;

  // One predicted result request.
  typedef struct packed {
    logic [u8dv_pkg::CP_WIDTH-1:0]    code_point;
    logic                             char_done;
    logic                             seq_error;
    logic                             string_done;
    logic                             string_valid;
    logic [u8dv_pkg::TOTAL_WIDTH-1:0] char_total;
  } decode_result_t;

  localparam int RANDOM_ITEMS = 950;
  localparam int TAIL_CYCLES  = 8;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       in_data_byte = 8'h00;
  logic                             in_end_of_string = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [u8dv_pkg::CP_WIDTH-1:0]    out_code_point;
  logic                             out_char_done;
  logic                             out_seq_error;
  logic                             out_string_done;
  logic                             out_string_valid;
  logic [u8dv_pkg::TOTAL_WIDTH-1:0] out_char_total;

  byte_req_t      byte_q[$];
  decode_result_t want_decodes[$];
  int             stim_total = 0;
  int             bytes_taken = 0;
  int             errors = 0;
  logic           in_fire = 1'b0;

  // Predictor state, mirrors the decoder registers.
  logic [1:0]                       dec_pend = '0;
  logic [u8dv_pkg::CP_WIDTH-1:0]    dec_part = '0;
  u8dv_pkg::cont_limit_t            dec_lim = u8dv_pkg::LIM_ANY;
  logic                             dec_err = 1'b0;
  logic [u8dv_pkg::COUNT_WIDTH-1:0] dec_tally = '0;

  utf8_stream_decode_validate u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_char_done    (out_char_done),
    .out_seq_error    (out_seq_error),
    .out_string_done  (out_string_done),
    .out_string_valid (out_string_valid),
    .out_char_total   (out_char_total)
  );

  always #6 clk = ~clk;

  // Decode one accepted byte; returns 1 when the byte causes a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output decode_result_t res);
    bit                            done;
    bit                            err;
    logic [u8dv_pkg::CP_WIDTH-1:0] cp;
    logic [7:0]                    lo;
    logic [7:0]                    hi;
    longint unsigned               tally_wide;
    done = 1'b0;
    err  = 1'b0;
    cp   = '0;
    res  = '0;
    if (!dec_err) begin
      if (dec_pend == 2'd0) begin
        if (b < 8'h80) begin
          cp   = u8dv_pkg::CP_WIDTH'(b);
          done = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          dec_part = u8dv_pkg::CP_WIDTH'(b[4:0]);
          dec_pend = 2'd1;
          dec_lim  = u8dv_pkg::LIM_ANY;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          dec_part = u8dv_pkg::CP_WIDTH'(b[3:0]);
          dec_pend = 2'd2;
          dec_lim  = (b == 8'hE0) ? u8dv_pkg::LIM_E0 :
                     (b == 8'hED) ? u8dv_pkg::LIM_ED : u8dv_pkg::LIM_ANY;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          dec_part = u8dv_pkg::CP_WIDTH'(b[2:0]);
          dec_pend = 2'd3;
          dec_lim  = (b == 8'hF0) ? u8dv_pkg::LIM_F0 :
                     (b == 8'hF4) ? u8dv_pkg::LIM_F4 : u8dv_pkg::LIM_ANY;
        end else begin
          err = 1'b1;
        end
      end else begin
        // The first continuation byte may be narrowed by the lead byte.
        lo = 8'h80;
        hi = 8'hBF;
        case (dec_lim)
          u8dv_pkg::LIM_E0: lo = 8'hA0;
          u8dv_pkg::LIM_ED: hi = 8'h9F;
          u8dv_pkg::LIM_F0: lo = 8'h90;
          u8dv_pkg::LIM_F4: hi = 8'h8F;
          default: ;
        endcase
        if (b >= lo && b <= hi) begin
          dec_part = {dec_part[u8dv_pkg::CP_WIDTH-7:0], b[5:0]};
          dec_lim  = u8dv_pkg::LIM_ANY;
          dec_pend = dec_pend - 2'd1;
          if (dec_pend == 2'd0) begin
            cp   = dec_part;
            done = 1'b1;
          end
        end else begin
          err = 1'b1;
        end
      end
      // A final byte that leaves a sequence open truncates it.
      if (eos && !err && dec_pend != 2'd0) err = 1'b1;
      if (err) begin
        dec_err  = 1'b1;
        dec_pend = '0;
        dec_part = '0;
        dec_lim  = u8dv_pkg::LIM_ANY;
      end
      if (done && dec_tally != '1) dec_tally = dec_tally + 1'b1;
    end
    if (!(done || err || eos)) return 1'b0;
    tally_wide = 64'(dec_tally);
    res.code_point   = cp;
    res.char_done    = done;
    res.seq_error    = err;
    res.string_done  = eos;
    res.string_valid = eos && !dec_err;
    if (eos) begin
      res.char_total = (tally_wide > 64'({u8dv_pkg::TOTAL_WIDTH{1'b1}})) ?
                       {u8dv_pkg::TOTAL_WIDTH{1'b1}} :
                       tally_wide[u8dv_pkg::TOTAL_WIDTH-1:0];
      dec_pend  = '0;
      dec_part  = '0;
      dec_lim   = u8dv_pkg::LIM_ANY;
      dec_err   = 1'b0;
      dec_tally = '0;
    end
    return 1'b1;
  endfunction

  // Stimulus helpers.
  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back('{data: b, eos: 1'b0});
  endtask

  task automatic end_string();
    byte_q[byte_q.size()-1].eos = 1'b1;
  endtask

  task automatic add_char(input int unsigned cp);
    if (cp < 32'h80) begin
      push_byte(cp[7:0]);
    end else if (cp < 32'h800) begin
      push_byte(8'hC0 | cp[10:6]);
      push_byte(8'h80 | cp[5:0]);
    end else if (cp < 32'h10000) begin
      push_byte(8'hE0 | cp[15:12]);
      push_byte(8'h80 | cp[11:6]);
      push_byte(8'h80 | cp[5:0]);
    end else begin
      push_byte(8'hF0 | cp[20:18]);
      push_byte(8'h80 | cp[17:12]);
      push_byte(8'h80 | cp[11:6]);
      push_byte(8'h80 | cp[5:0]);
    end
  endtask

  // Random scalar value, weighted toward short encodings and boundaries.
  function automatic int unsigned rand_cp();
    int unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 32'h7F);
      4, 5:       v = $urandom_range(32'h80, 32'h7FF);
      6, 7: begin
        v = $urandom_range(32'h800, 32'hF7FF);
        if (v >= 32'hD800) v = v + 32'h800;
      end
      8:          v = $urandom_range(32'h10000, 32'h10FFFF);
      default: begin
        case ($urandom_range(0, 9))
          0: v = 32'h0;
          1: v = 32'h7F;
          2: v = 32'h80;
          3: v = 32'h7FF;
          4: v = 32'h800;
          5: v = 32'hD7FF;
          6: v = 32'hE000;
          7: v = 32'hFFFF;
          8: v = 32'h10000;
          default: v = 32'h10FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // A lead byte with fewer continuation bytes than it needs.
  task automatic push_open_seq();
    int n;
    int k;
    n = int'($urandom_range(1, 3));
    case (n)
      1: push_byte(8'($urandom_range(8'hC2, 8'hDF)));
      2: push_byte(8'($urandom_range(8'hE1, 8'hEC)));
      default: push_byte(8'($urandom_range(8'hF1, 8'hF3)));
    endcase
    k = int'($urandom_range(0, n - 1));
    repeat (k) push_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    int kind;
    int v;
    // Valid string with the smallest byte and the largest scalar value.
    push_byte(8'h00); push_byte(8'hC2); push_byte(8'h80);
    push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
    end_string();
    // Overlong after E0, then absorbed bytes; count stops at the error.
    push_byte(8'h41); push_byte(8'hE0); push_byte(8'h9F);
    push_byte(8'h41); push_byte(8'hFF);
    end_string();
    // Surrogate half is the error byte, the final byte is absorbed.
    push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80);
    end_string();
    // Truncated four-byte sequence on the final byte.
    push_byte(8'hF0); push_byte(8'h90);
    end_string();
    // Stray continuation as the only, final byte.
    push_byte(8'h80);
    end_string();
    // Lead byte beyond the scalar range.
    push_byte(8'hF5); push_byte(8'h7F);
    end_string();
    // Overlong two-byte lead.
    push_byte(8'hC0); push_byte(8'hAF);
    end_string();

    // Random strings: mostly well-formed, some broken, some noise.
    while (byte_q.size() < RANDOM_ITEMS) begin
      kind = int'($urandom_range(0, 19));
      if (kind < 14) begin
        repeat ($urandom_range(1, 12)) add_char(rand_cp());
        end_string();
      end else if (kind < 17) begin
        repeat ($urandom_range(0, 5)) add_char(rand_cp());
        case ($urandom_range(0, 7))
          0: push_byte(8'($urandom_range(8'h80, 8'hBF)));
          1: begin
            v = int'($urandom_range(0, 12));
            push_byte(8'((v < 2) ? 8'hC0 + v : 8'hF5 + v - 2));
          end
          2: begin push_byte(8'hE0); push_byte(8'($urandom_range(8'h80, 8'h9F))); end
          3: begin push_byte(8'hED); push_byte(8'($urandom_range(8'hA0, 8'hBF))); end
          4: begin push_byte(8'hF4); push_byte(8'($urandom_range(8'h90, 8'hBF))); end
          5: begin push_byte(8'hF0); push_byte(8'($urandom_range(8'h80, 8'h8F))); end
          6: begin
            push_open_seq();
            push_byte(8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 8'h7F)
                                                     : $urandom_range(8'hC0, 8'hFF)));
          end
          default: push_open_seq();
        endcase
        // Bytes after the error are absorbed; with none, the error is final.
        repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)));
        end_string();
      end else begin
        repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
        end_string();
      end
    end

    // A short well-formed string at the end.
    repeat ($urandom_range(1, 6)) add_char(rand_cp());
    end_string();
    stim_total = byte_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(bytes_taken == stim_total && want_decodes.size() == 0)) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb_utf8_stream_decode_validate: done, clean");
    end else begin
      $display("tb_utf8_stream_decode_validate: done, errors");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #60000000;
    $display("tb_utf8_stream_decode_validate: done, errors");
    $finish;
  end

  // Sender: bursts of requests with random gaps between them.
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    byte_req_t req;
    logic      nv;
    nv = in_valid;
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        nv = 1'b0;
      end else if (byte_q.size() > 0) begin
        req = byte_q.pop_front();
        in_data_byte     <= req.data;
        in_end_of_string <= req.eos;
        nv = 1'b1;
        if (burst_left <= 1) begin
          burst_left = int'($urandom_range(1, 24));
          gap_left   = int'(($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                                        : $urandom_range(0, 2));
        end else begin
          burst_left--;
        end
      end else begin
        nv = 1'b0;
      end
    end
    in_valid <= nv;
  end

  // Receiver: stall pattern that picks a new mode whenever its random countdown runs out.
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = int'($urandom_range(0, 3));
      stall_left = int'($urandom_range(20, 200));
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase == 2) ? 0 : stall_phase + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (stall_phase == 0);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Compare one field of a result request.
  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // Monitor: predicts on each accepted byte and checks each accepted result.
  always @(posedge clk) begin
    decode_result_t res;
    decode_result_t want;
    in_fire <= in_valid && in_ready && rst_n;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        bytes_taken++;
        if (decode_byte(in_data_byte, in_end_of_string, res)) want_decodes.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (want_decodes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cp %0h done %0b err %0b",
                   $time, out_code_point, out_char_done, out_seq_error);
          errors++;
        end else begin
          want = want_decodes.pop_front();
          check_field("code_point", 32'(want.code_point), 32'(out_code_point));
          check_field("char_done", 32'(want.char_done), 32'(out_char_done));
          check_field("seq_error", 32'(want.seq_error), 32'(out_seq_error));
          check_field("string_done", 32'(want.string_done), 32'(out_string_done));
          check_field("string_valid", 32'(want.string_valid), 32'(out_string_valid));
          check_field("char_total", 32'(want.char_total), 32'(out_char_total));
        end
      end
    end
  end

endmodule
